@@ design/bitmap_to_gdram_row_writer_macros.svh @@
// Assertion macros used by the checker file of the row writer.
`ifndef BITMAP_TO_GDRAM_ROW_WRITER_MACROS_SVH
`define BITMAP_TO_GDRAM_ROW_WRITER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define B2G_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define B2G_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/b2g_pkg.sv @@
// Shared constants and types of the bitmap to graphic RAM row writer.
package b2g_pkg;

  // Image store geometry: 32 rows of 32 bytes.
  localparam int IMG_WIDTH  = 8;
  localparam int IMG_DEPTH  = 1024;
  localparam int IMG_AW     = 10;
  localparam int ROW_BYTES  = 32;

  // Stream widths.
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;

  // Item kinds carried in the slave tuser bit.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Display address command prefix.
  localparam logic [7:0] ADDR_CMD = 8'h80;

  // One result item as it leaves the block.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } out_t;

  // A result issued by the sequencer; memory bytes arrive in the next cycle.
  typedef struct packed {
    logic       valid;
    logic       is_mem;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } issue_t;

  // Control of the image memory ports.
  typedef struct packed {
    logic                 we;
    logic [IMG_AW-1:0]    waddr;
    logic [IMG_WIDTH-1:0] wdata;
    logic                 re;
    logic [IMG_AW-1:0]    raddr;
  } ram_ctl_t;

endpackage

@@ design/b2g_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module b2g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle; a read sees the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/b2g_seq.sv @@
// Sequencer: clearing pass, read-modify-write loads and render issue.
module b2g_seq
  import b2g_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [0:0]           s_tuser,
  output issue_t               issue,
  input  logic                 issue_ready,
  output ram_ctl_t             ram,
  input  logic [IMG_WIDTH-1:0] rdata
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_RENDER = 2'd3;

  localparam logic [IMG_AW-1:0] CLEAR_LAST  = IMG_AW'(IMG_DEPTH - 1);
  localparam logic [IMG_AW-1:0] LOAD_LAST   = IMG_AW'(7);
  localparam logic [IMG_AW-1:0] RENDER_LAST = IMG_AW'(ROW_BYTES + 1);
  localparam logic [IMG_AW-1:0] FIRST_DATA  = IMG_AW'(2);

  logic [1:0]        state;
  logic [IMG_AW-1:0] step;
  logic [9:0]        idx;
  logic [7:0]        pix;
  logic [4:0]        row;
  logic              lw_valid;
  logic [IMG_AW-1:0] lw_addr;
  logic              lw_bit;

  logic              accept;
  logic              fire;
  logic [IMG_AW-1:0] load_addr;
  logic [4:0]        col_byte;
  logic [7:0]        mask;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Source byte at page p, column x: image row {p[1:0], k}, byte {p[2], x[6:3]}.
  assign load_addr = {idx[8:7], step[2:0], idx[9], idx[6:3]};
  assign mask      = 8'h80 >> idx[2:0];
  assign col_byte  = step[4:0] - 5'd2;

  // Render results: two address commands, then the row's bytes from memory.
  always_comb begin
    issue.valid    = (state == ST_RENDER);
    issue.is_mem   = (step >= FIRST_DATA);
    issue.is_data  = (step >= FIRST_DATA);
    issue.bus_byte = (step == '0) ? (ADDR_CMD | {3'b000, row}) : ADDR_CMD;
    issue.last     = (step == RENDER_LAST);
  end

  assign fire = issue.valid && issue_ready;

  // Memory ports: clearing writes, load write-back, load and render reads.
  always_comb begin
    ram.we    = 1'b0;
    ram.waddr = lw_addr;
    ram.wdata = lw_bit ? (rdata | mask) : (rdata & ~mask);
    ram.re    = 1'b0;
    ram.raddr = load_addr;
    if (state == ST_CLEAR) begin
      ram.we    = 1'b1;
      ram.waddr = step;
      ram.wdata = '0;
    end else if (lw_valid) begin
      ram.we    = 1'b1;
    end
    if (state == ST_LOAD) begin
      ram.re    = 1'b1;
    end else if (state == ST_RENDER) begin
      ram.re    = fire && issue.is_mem;
      ram.raddr = {row, col_byte};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step     <= '0;
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= (state == ST_LOAD);
      case (state)
        ST_CLEAR: begin
          step <= step + 1'b1;
          if (step == CLEAR_LAST) begin
            state <= ST_IDLE;
            step  <= '0;
          end
        end
        ST_IDLE: begin
          step <= '0;
          if (accept) begin
            state <= (s_tuser[0] == CMD_LOAD) ? ST_LOAD : ST_RENDER;
          end
        end
        ST_LOAD: begin
          step <= step + 1'b1;
          if (step == LOAD_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_RENDER: begin
          if (fire) begin
            step <= step + 1'b1;
            if (step == RENDER_LAST) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item fields and the pending write-back of a load.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= s_tdata[9:0];
      pix <= s_tdata[17:10];
      row <= s_tdata[22:18];
    end
    lw_addr <= load_addr;
    lw_bit  <= pix[step[2:0]];
  end

endmodule

@@ design/b2g_outq.sv @@
// Output stage: memory return alignment and a two-item queue to the master side.
module b2g_outq
  import b2g_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  issue_t               issue,
  output logic                 issue_ready,
  input  logic [IMG_WIDTH-1:0] rdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);

  logic       st_valid;
  logic       st_is_mem;
  logic       st_is_data;
  logic [7:0] st_byte;
  logic       st_last;

  out_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic [2:0] occ;
  out_t       head;
  out_t       entry;

  assign head     = q[rp];
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = head.bus_byte;
  assign m_tuser  = head.is_data;
  assign m_tlast  = head.last;

  assign pop  = m_tvalid && m_tready;
  assign push = st_valid;

  // An item may be issued when the queue will still have room for it.
  assign occ         = {1'b0, cnt} + {2'b00, st_valid} - {2'b00, pop};
  assign issue_ready = (occ < 3'd2);

  always_comb begin
    entry.is_data  = st_is_data;
    entry.bus_byte = st_is_mem ? rdata : st_byte;
    entry.last     = st_last;
  end

  // Alignment stage and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      wp       <= 1'b0;
      rp       <= 1'b0;
      cnt      <= 2'd0;
    end else begin
      st_valid <= issue.valid && issue_ready;
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload of the stage and the queue.
  always_ff @(posedge clk) begin
    st_is_mem  <= issue.is_mem;
    st_is_data <= issue.is_data;
    st_byte    <= issue.bus_byte;
    st_last    <= issue.last;
    if (push) begin
      q[wp] <= entry;
    end
  end

endmodule

@@ design/bitmap_to_gdram_row_writer.sv @@
// Top level of the bitmap to graphic RAM row writer.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: kind (0 load, 1 render); tdata: index, pixels, row
//   m_*      out        tuser: data flag; tdata: bus byte; tlast: end of row
//
// Reset starts a clearing pass over all 1024 bytes, one zero byte a cycle, with s_tready low.
// A load item holds the input while it reads eight image bytes, each byte written back
// in the cycle after its read. A render item holds it while two address commands and
// the row's 32 bytes issue, one a cycle while the two-item output queue has room; each
// result is registered in the alignment stage, then queued for the master side.
// Output stalls hold the queue head.
module bitmap_to_gdram_row_writer
  import b2g_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // source_index, source_byte, render_row
  input  logic [0:0]           s_tuser,  // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // bus_byte
  output logic [0:0]           m_tuser,  // is_data
  output logic                 m_tlast
);

  issue_t               issue;
  logic                 issue_ready;
  ram_ctl_t             ram;
  logic [IMG_WIDTH-1:0] rdata;

  // Image store.
  b2g_ram #(
    .WIDTH (IMG_WIDTH),
    .DEPTH (IMG_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // Item sequencer.
  b2g_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .issue       (issue),
    .issue_ready (issue_ready),
    .ram         (ram),
    .rdata       (rdata)
  );

  // Result queue.
  b2g_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_ready (issue_ready),
    .rdata       (rdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

@@ design/b2g_checker.sv @@
// Port-level checker of the row writer and its bind to the top level.
`include "bitmap_to_gdram_row_writer_macros.svh"

module b2g_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // The clearing pass keeps the input closed right after reset.
  `B2G_ASSERT_NEXT(a_clear_closed, clk, 1'b0, rst, !s_tready, "input open during clear")

  // No result is shown right after reset.
  `B2G_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result after reset")

  // The end of a row is always a data byte.
  `B2G_ASSERT_NOW(a_last_data, clk, rst, m_tvalid && m_tlast, m_tuser[0], "tlast on command")

  // Command items always carry the address prefix.
  `B2G_ASSERT_NOW(a_cmd_prefix, clk, rst, m_tvalid && !m_tuser[0], m_tdata[7], "bad command")

  // A stalled item holds.
  `B2G_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast), "item changed in stall")

endmodule

bind bitmap_to_gdram_row_writer b2g_checker u_b2g_checker (.*);
